// ----- rtl/rbl_pkg.sv -----
// Shared types, constants and helper functions for the RGB breathing LED generator.
`default_nettype none

package rbl_pkg;

    localparam logic [15:0] SEED_RESET    = 16'hBEEF;
    localparam logic [7:0]  INC_RESET     = 8'd1;
    localparam logic [7:0]  HUE_MASK      = 8'h1F;
    localparam logic [7:0]  HUE_MIN_JUMP  = 8'h10;
    localparam logic [7:0]  FULL_SCALE    = 8'd255;
    localparam logic [7:0]  SEGMENT       = 8'(255 / 3);

    localparam int          ADDR_W        = 3;
    localparam logic        REG_SEED      = 1'b0;
    localparam logic        REG_INC       = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_JUMP,
        ST_SQUARE,
        ST_SCALE,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_FINISH
    } rbl_state_t;

    typedef struct packed {
        logic       load;
        logic [7:0] a;
        logic [7:0] b;
    } arith_req_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

    function automatic rgb_t wheel(input logic [7:0] h);
        rgb_t       c;
        logic [7:0] d;
        logic [9:0] t;
        if (h < SEGMENT)
        begin
            d = h;
        end
        else if (h < 8'(2 * 85))
        begin
            d = h - SEGMENT;
        end
        else
        begin
            d = h - 8'(2 * 85);
        end
        t = {2'b00, d} + {1'b0, d, 1'b0};
        if (h < SEGMENT)
        begin
            c.r = FULL_SCALE - t[7:0];
            c.g = t[7:0];
            c.b = 8'd0;
        end
        else if (h < 8'(2 * 85))
        begin
            c.r = 8'd0;
            c.g = FULL_SCALE - t[7:0];
            c.b = t[7:0];
        end
        else
        begin
            c.r = t[7:0];
            c.g = 8'd0;
            c.b = FULL_SCALE - t[7:0];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rbl_arith.sv -----
// Shared 8x8 multiplier with registered product and divide-by-255 of that product.
`default_nettype none

module rbl_arith (
    input  wire                 clk,
    input  rbl_pkg::arith_req_t req,
    output logic [7:0]          quotient
);
    import rbl_pkg::*;

    logic [15:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= {8'd0, req.a} * {8'd0, req.b};
        end
    end

    assign quotient = div255(prod_reg);

endmodule

`default_nettype wire

// ----- rtl/rbl_ctrl.sv -----
// Sequencer: LFSR, hue and phase state, multiplier scheduling and the result register.
`default_nettype none

module rbl_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  seed_load,
    input  wire  [15:0]          seed,
    input  wire  [7:0]           increment,
    input  wire                  tick_valid,
    output logic                 tick_ready,
    input  wire                  tick,
    output logic                 duty_valid,
    input  wire                  duty_ready,
    output logic [7:0]           red_duty,
    output logic [7:0]           green_duty,
    output logic [7:0]           blue_duty,
    output rbl_pkg::arith_req_t  req,
    input  wire  [7:0]           quotient
);
    import rbl_pkg::*;

    rbl_state_t  state_reg, state_next;
    logic [15:0] lfsr_reg, lfsr_next;
    logic [7:0]  hue_reg, hue_next;
    logic [7:0]  phase_reg, phase_next;
    logic        started_reg, started_next;
    logic [7:0]  bright_reg, bright_next;
    logic [7:0]  red_work_reg, red_work_next;
    logic [7:0]  green_work_reg, green_work_next;
    logic        valid_reg, valid_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;

    logic [15:0] lfsr_adv;
    logic [7:0]  tri_val;
    rgb_t        color;

    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign tri_val  = phase_reg[7] ? {~phase_reg[6:0], 1'b0} : {phase_reg[6:0], 1'b0};
    assign color    = wheel(hue_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lfsr_reg    <= SEED_RESET;
            hue_reg     <= 8'd0;
            phase_reg   <= 8'd0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lfsr_reg    <= lfsr_next;
            hue_reg     <= hue_next;
            phase_reg   <= phase_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bright_reg     <= bright_next;
        red_work_reg   <= red_work_next;
        green_work_reg <= green_work_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        lfsr_next       = lfsr_reg;
        hue_next        = hue_reg;
        phase_next      = phase_reg;
        started_next    = started_reg;
        bright_next     = bright_reg;
        red_work_next   = red_work_reg;
        green_work_next = green_work_reg;
        valid_next      = valid_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        tick_ready      = 1'b0;
        req.load        = 1'b0;
        req.a           = tri_val;
        req.b           = tri_val;

        if (valid_reg && duty_ready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                if (seed_load)
                begin
                    lfsr_next = seed;
                end
                if (tick_valid && tick)
                begin
                    if (!started_reg)
                    begin
                        state_next = ST_SEED;
                    end
                    else if (phase_reg == 8'd0)
                    begin
                        state_next = ST_JUMP;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SEED:
            begin
                lfsr_next    = lfsr_adv;
                hue_next     = lfsr_adv[7:0];
                started_next = 1'b1;
                state_next   = (phase_reg == 8'd0) ? ST_JUMP : ST_SQUARE;
            end
            ST_JUMP:
            begin
                lfsr_next  = lfsr_adv;
                hue_next   = hue_reg + (lfsr_adv[7:0] & HUE_MASK) + HUE_MIN_JUMP;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                req.load   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                bright_next = {1'b0, quotient[7:1]};
                state_next  = ST_RED;
            end
            ST_RED:
            begin
                req.load   = 1'b1;
                req.a      = color.r;
                req.b      = bright_reg;
                state_next = ST_GREEN;
            end
            ST_GREEN:
            begin
                red_work_next = quotient;
                req.load      = 1'b1;
                req.a         = color.g;
                req.b         = bright_reg;
                state_next    = ST_BLUE;
            end
            ST_BLUE:
            begin
                green_work_next = quotient;
                req.load        = 1'b1;
                req.a           = color.b;
                req.b           = bright_reg;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!valid_reg || duty_ready)
                begin
                    valid_next = 1'b1;
                    red_next   = red_work_reg;
                    green_next = green_work_reg;
                    blue_next  = quotient;
                    phase_next = phase_reg + increment;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign duty_valid = valid_reg;
    assign red_duty   = red_reg;
    assign green_duty = green_reg;
    assign blue_duty  = blue_reg;

endmodule

`default_nettype wire

// ----- rtl/rgb_breathing_led_generator.sv -----
// Top level of the RGB breathing LED generator: register port and block wiring.
//
// Each accepted item with tick high yields one red/green/blue duty triple; an item
// with tick low is accepted while idle and yields nothing. A tick's result becomes
// valid as the sequencer returns to idle and is ready again, so a new tick is taken
// only after the last one is done. Each LFSR draw has its own state: seed, then hue
// jump on the first tick (the phase starts at zero), and the hue jump alone whenever
// the breathing phase is zero. The single 8x8 multiplier is used four times per item
// (brightness square, then red, green, blue scaling), each product divided by 255
// the cycle after. tick_ready is high only while the sequencer is idle; a finished
// result waits in the output register and the next tick is accepted meanwhile,
// while a second finished result holds the sequencer until the first is taken.
// Registers: 0x0 random_seed (16 bit, writing it reloads the LFSR), 0x4
// phase_increment (8 bit). Write only while idle.
`default_nettype none

module rgb_breathing_led_generator (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [rbl_pkg::ADDR_W-1:0] paddr,
    input  wire  [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire                        tick_valid,
    output logic                       tick_ready,
    input  wire                        tick,
    output logic                       duty_valid,
    input  wire                        duty_ready,
    output logic [7:0]                 red_duty,
    output logic [7:0]                 green_duty,
    output logic [7:0]                 blue_duty
);
    import rbl_pkg::*;

    logic [15:0] seed_reg;
    logic [7:0]  inc_reg;
    logic        wr_en;
    logic        seed_load;
    arith_req_t  req;
    logic [7:0]  quotient;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign seed_load = wr_en && (paddr[2] == REG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            inc_reg  <= INC_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SEED)
            begin
                seed_reg <= pwdata[15:0];
            end
            else
            begin
                inc_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SEED: prdata = {16'd0, seed_reg};
            REG_INC:  prdata = {24'd0, inc_reg};
            default:  prdata = 32'd0;
        endcase
    end

    rbl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_load  (seed_load),
        .seed       (pwdata[15:0]),
        .increment  (inc_reg),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .duty_valid (duty_valid),
        .duty_ready (duty_ready),
        .red_duty   (red_duty),
        .green_duty (green_duty),
        .blue_duty  (blue_duty),
        .req        (req),
        .quotient   (quotient)
    );

    rbl_arith u_arith (
        .clk      (clk),
        .req      (req),
        .quotient (quotient)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the RGB breathing LED generator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbl_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                tick_valid;
    logic                tick_ready;
    logic                tick;
    logic                duty_valid;
    logic                duty_ready;
    logic [7:0]          red_duty;
    logic [7:0]          green_duty;
    logic [7:0]          blue_duty;

    logic [15:0]         seed_model;
    logic [7:0]          inc_model;
    logic [15:0]         lfsr_model;
    logic [7:0]          hue_model;
    logic [7:0]          phase_model;
    bit                  started_model;

    rgb_t                expected_duties[$];
    int                  errors;
    int                  idle_cycles;
    bit                  quiet;

    rgb_breathing_led_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .duty_valid (duty_valid),
        .duty_ready (duty_ready),
        .red_duty   (red_duty),
        .green_duty (green_duty),
        .blue_duty  (blue_duty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] lfsr_draw();
        logic fb;
        fb = lfsr_model[0] ^ lfsr_model[2] ^ lfsr_model[3] ^ lfsr_model[5];
        lfsr_model = {fb, lfsr_model[15:1]};
        return lfsr_model[7:0];
    endfunction

    function automatic rgb_t breath_step();
        rgb_t        duty;
        int unsigned p;
        int unsigned ramp;
        int unsigned level;
        int unsigned h;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        logic [7:0]  rnd;
        if (!started_model)
        begin
            hue_model = lfsr_draw();
            started_model = 1'b1;
        end
        if (phase_model == 8'd0)
        begin
            rnd = lfsr_draw();
            hue_model = hue_model + (rnd & HUE_MASK) + HUE_MIN_JUMP;
        end
        p = phase_model;
        ramp = (p < 128) ? 2 * p : 2 * (255 - p);
        level = (ramp * ramp / 255) / 2;
        h = hue_model;
        if (h < 85)
        begin
            r = 255 - 3 * h;
            g = 3 * h;
            b = 0;
        end
        else if (h < 170)
        begin
            r = 0;
            g = 255 - 3 * (h - 85);
            b = 3 * (h - 85);
        end
        else
        begin
            r = 3 * (h - 170);
            g = 0;
            b = 255 - 3 * (h - 170);
        end
        duty.r = 8'(r * level / 255);
        duty.g = 8'(g * level / 255);
        duty.b = 8'(b * level / 255);
        phase_model = phase_model + inc_model;
        return duty;
    endfunction

    task automatic send_item(input logic value, input bit gaps);
        @(negedge clk);
        if (gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            tick_valid <= 1'b0;
            tick       <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= value;
        do
            @(posedge clk);
        while (!tick_ready);
        if (value)
        begin
            expected_duties.push_back(breath_step());
        end
    endtask

    task automatic settle();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (expected_duties.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_SEED)
        begin
            seed_model = value[15:0];
            lfsr_model = value[15:0];
        end
        else
        begin
            inc_model = value[7:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_seed(input logic [15:0] seed);
        write_reg(REG_SEED, ({$urandom} & 32'hFFFF_0000) | {16'd0, seed});
    endtask

    task automatic write_inc(input logic [7:0] inc);
        write_reg(REG_INC, ({$urandom} & 32'hFFFF_FF00) | {24'd0, inc});
    endtask

    task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_duty
        rgb_t want;
        if (rst_n && duty_valid && duty_ready)
        begin
            if (expected_duties.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item expected none actual r=%0d g=%0d b=%0d",
                         $time, red_duty, green_duty, blue_duty);
            end
            else
            begin
                want = expected_duties.pop_front();
                report("red_duty", want.r, red_duty);
                report("green_duty", want.g, green_duty);
                report("blue_duty", want.b, blue_duty);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_valid && tick_ready) || (duty_valid && duty_ready) ||
                (psel && penable && pwrite && pready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : drive_duty_ready
        logic hold;
        duty_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            hold = !(!quiet && $urandom_range(0, 3) == 0);
            duty_ready <= hold;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    end

    task automatic test_reset_defaults();
        repeat (4) send_item(1'b1, 1'b1);
    endtask

    task automatic test_idle_ticks();
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
    endtask

    task automatic test_zero_increment();
        settle();
        write_inc(8'd0);
        repeat (3) send_item(1'b1, 1'b1);
    endtask

    task automatic test_extreme_settings();
        settle();
        write_seed(16'hFFFF);
        write_inc(8'd255);
        repeat (3) send_item(1'b1, 1'b1);
        settle();
        write_inc(8'd128);
        repeat (3) send_item(1'b1, 1'b1);
    endtask

    task automatic test_zero_seed();
        settle();
        write_seed(16'h0000);
        write_inc(8'd0);
        repeat (3) send_item(1'b1, 1'b1);
        settle();
        write_seed(16'h0001);
        write_inc(8'd1);
        repeat (2) send_item(1'b1, 1'b1);
    endtask

    task automatic test_random_sweep();
        logic [15:0] seed;
        logic [7:0]  inc;
        for (int k = 0; k < 8; k++)
        begin
            settle();
            quiet = (k == 3) || (k == 7);
            seed = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 3))
                0:       inc = 8'd1 << $urandom_range(0, 7);
                1:       inc = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd255;
                default: inc = 8'($urandom_range(1, 255));
            endcase
            write_seed(seed);
            write_inc(inc);
            repeat (205) send_item($urandom_range(0, 7) != 0, 1'b1);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tick_valid    = 1'b0;
        tick          = 1'b0;
        quiet         = 1'b0;
        errors        = 0;
        idle_cycles   = 0;
        seed_model    = SEED_RESET;
        inc_model     = INC_RESET;
        lfsr_model    = SEED_RESET;
        hue_model     = 8'd0;
        phase_model   = 8'd0;
        started_model = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_idle_ticks();
        test_zero_increment();
        test_extreme_settings();
        test_zero_seed();
        test_random_sweep();

        settle();
        repeat (20) @(negedge clk);
        if (errors == 0 && expected_duties.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
